>>> design/csw_pkg.sv
package csw_pkg;
  localparam int WaitDepth = 8;
  localparam int OccW = $clog2(WaitDepth + 1);
  localparam int IdxW = (WaitDepth > 1) ? $clog2(WaitDepth) : 1;

  localparam logic [1:0] OP_TAKE   = 2'd0;
  localparam logic [1:0] OP_GIVE   = 2'd1;
  localparam logic [1:0] OP_RESUME = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BLOCKED  = 3'd1;
  localparam logic [2:0] ST_TIMEOUT  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam logic REG_MAX  = 1'b0;
  localparam logic REG_INIT = 1'b1;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] task_id;
    logic [7:0] task_priority;
    logic       no_wait;
    logic       current_valid;
    logic [7:0] current_priority;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        woken_valid;
    logic [7:0]  woken_task;
    logic        preempt;
    logic [15:0] count_now;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctl_cmd_t;
endpackage

>>> design/csw_if.sv
interface csw_in_if;
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic [7:0] task_id;
  logic [7:0] task_priority;
  logic no_wait;
  logic current_valid;
  logic [7:0] current_priority;
  modport source(output valid, operation, task_id, task_priority, no_wait,
                 current_valid, current_priority, input ready);
  modport sink(input valid, operation, task_id, task_priority, no_wait,
               current_valid, current_priority, output ready);
endinterface

interface csw_out_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic woken_valid;
  logic [7:0] woken_task;
  logic preempt;
  logic [15:0] count_now;
  modport source(output valid, status, woken_valid, woken_task, preempt,
                 count_now, input ready);
  modport sink(input valid, status, woken_valid, woken_task, preempt,
               count_now, output ready);
endinterface

interface csw_cfg_if;
  logic valid;
  logic ready;
  logic [7:0] index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> design/csw_ctrl.sv
module csw_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output csw_pkg::ctl_cmd_t cmd
);
  import csw_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;

  logic [1:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;

  assign in_ready    = (state_r == S_IDLE) && (!ovalid_r || out_ready);
  assign out_valid   = ovalid_r;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.execute = (state_r == S_EXEC);

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: if (cmd.capture) state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt  = S_IDLE;
        ovalid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> !cmd.execute) else $error("exec twice");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> out_valid) else $error("no word after exec");
  a_cap_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.execute) else $error("capture lost");
endmodule

>>> design/csw_dp.sv
module csw_dp (
  input  logic clk,
  input  logic rst_n,
  input  csw_pkg::ctl_cmd_t cmd,
  input  csw_pkg::in_word_t in_word,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output csw_pkg::out_word_t out_word
);
  import csw_pkg::*;

  in_word_t        req_r;
  out_word_t       res_r, res_nxt;
  logic [15:0]     max_r, count_r, count_nxt;
  logic [OccW-1:0] occ_r, occ_nxt;
  logic [7:0]      ids_r [WaitDepth];
  logic [7:0]      pri_r [WaitDepth];
  logic [7:0]      ids_nxt [WaitDepth];
  logic [7:0]      pri_nxt [WaitDepth];
  logic [WaitDepth-1:0] valid_e, before_e, match_e, first_m;
  logic            found;

  always_comb begin
    for (int i = 0; i < WaitDepth; i++) begin
      valid_e[i]  = (OccW'(i) < occ_r);
      before_e[i] = valid_e[i] && (pri_r[i] <= req_r.task_priority);
      match_e[i]  = valid_e[i] && (ids_r[i] == req_r.task_id);
    end
    first_m = match_e & (~match_e + 1'b1);
    found   = |match_e;
  end

  always_comb begin
    logic below;
    res_nxt   = '0;
    count_nxt = count_r;
    occ_nxt   = occ_r;
    ids_nxt   = ids_r;
    pri_nxt   = pri_r;
    below     = 1'b0;
    unique case (req_r.operation)
      OP_TAKE: begin
        if (count_r != 16'd0) begin
          count_nxt = count_r - 16'd1;
        end else if (req_r.no_wait) begin
          res_nxt.status = ST_TIMEOUT;
        end else if (occ_r >= OccW'(WaitDepth)) begin
          res_nxt.status = ST_OVERFLOW;
        end else begin
          res_nxt.status = ST_BLOCKED;
          occ_nxt = occ_r + 1'b1;
          for (int i = 0; i < WaitDepth; i++) begin
            if (!before_e[i]) begin
              if (i > 0 && !before_e[(i > 0) ? i - 1 : 0]) begin
                ids_nxt[i] = ids_r[(i > 0) ? i - 1 : 0];
                pri_nxt[i] = pri_r[(i > 0) ? i - 1 : 0];
              end else begin
                ids_nxt[i] = req_r.task_id;
                pri_nxt[i] = req_r.task_priority;
              end
            end
          end
        end
      end
      OP_GIVE: begin
        if (occ_r != '0) begin
          res_nxt.woken_valid = 1'b1;
          res_nxt.woken_task  = ids_r[0];
          res_nxt.preempt     = req_r.current_valid &&
                                (pri_r[0] < req_r.current_priority);
          occ_nxt = occ_r - 1'b1;
          for (int i = 0; i + 1 < WaitDepth; i++) begin
            ids_nxt[i] = ids_r[i + 1];
            pri_nxt[i] = pri_r[i + 1];
          end
        end else if (count_r >= max_r) begin
          res_nxt.status = ST_FULL;
        end else begin
          count_nxt = count_r + 16'd1;
        end
      end
      OP_RESUME: begin
        if (found) begin
          res_nxt.status = ST_TIMEOUT;
          occ_nxt = occ_r - 1'b1;
          for (int i = 0; i + 1 < WaitDepth; i++) begin
            below = below | first_m[i];
            if (below) begin
              ids_nxt[i] = ids_r[i + 1];
              pri_nxt[i] = pri_r[i + 1];
            end
          end
        end
      end
      default: ;
    endcase
    res_nxt.count_now = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_word;
    if (cmd.execute) begin
      res_r <= res_nxt;
      ids_r <= ids_nxt;
      pri_r <= pri_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= 16'd1;
      count_r <= 16'd0;
      occ_r   <= '0;
    end else if (cfg_we && cfg_index == {7'd0, REG_MAX}) begin
      max_r <= cfg_data;
    end else if (cfg_we && cfg_index == {7'd0, REG_INIT}) begin
      count_r <= (cfg_data > max_r) ? max_r : cfg_data;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
      occ_r   <= occ_nxt;
    end
  end

  assign out_word = res_r;

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OccW'(WaitDepth)) else $error("occupancy too high");
  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && !cfg_we |=> (occ_r == $past(occ_r)) ||
      (occ_r == $past(occ_r) + 1'b1) || (occ_r == $past(occ_r) - 1'b1))
    else $error("occupancy jump");
  a_woken_give: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && res_nxt.woken_valid |-> req_r.operation == OP_GIVE)
    else $error("wake without give");
endmodule

>>> design/counting_semaphore_priority_wait_top.sv
// channel | dir | handshake          | word
// in_     | in  | in_valid/in_ready   | operation, task_id, priorities, flags
// out_    | out | out_valid/out_ready | status, woken_*, preempt, count_now
// cfg_    | in  | cfg_valid/cfg_ready | index 0 count limit, 1 initial count
// Each word: capture, then execute (count update or wait-queue update in the shift array).
// Result sits in an output register; next word taken once it is read.
// rst_n synchronous: count 0, max 1, queue empty.
// Stalls on out_ready hold the result and block new input.
module counting_semaphore_priority_wait_top (
  input logic clk,
  input logic rst_n,
  csw_in_if.sink    in_ch,
  csw_out_if.source out_ch,
  csw_cfg_if.sink   cfg_ch
);
  import csw_pkg::*;

  ctl_cmd_t  cmd;
  in_word_t  in_word;
  out_word_t out_word;

  assign cfg_ch.ready = 1'b1;
  assign in_word = '{operation: in_ch.operation, task_id: in_ch.task_id,
                     task_priority: in_ch.task_priority, no_wait: in_ch.no_wait,
                     current_valid: in_ch.current_valid,
                     current_priority: in_ch.current_priority};

  csw_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd(cmd)
  );

  csw_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_word(in_word),
    .cfg_we(cfg_ch.valid), .cfg_index(cfg_ch.index), .cfg_data(cfg_ch.data),
    .out_word(out_word)
  );

  assign out_ch.status      = out_word.status;
  assign out_ch.woken_valid = out_word.woken_valid;
  assign out_ch.woken_task  = out_word.woken_task;
  assign out_ch.preempt     = out_word.preempt;
  assign out_ch.count_now   = out_word.count_now;
endmodule
